/* design/kfip_pkg.sv */
// Package for the keyed Feistel index permutation: sizes, codes, the
// transaction token passed along the round cells, and shared helper functions.
// No dependencies.
`default_nettype none

package kfip_pkg;

  localparam int unsigned MAX_MODULUS    = 1024;
  localparam int unsigned MIN_MODULUS    = 32;
  localparam int unsigned ROUNDS         = 5;
  localparam int unsigned HALF_MOD_RESET = 32;

  localparam int unsigned HALF_W    = 10;  // width of one half and of a table entry
  localparam int unsigned MOD_W     = 11;  // width of the modulus register
  localparam int unsigned IDX_W     = 20;  // width of an index
  localparam int unsigned ROUND_W   = 3;   // width of the round select field
  localparam int unsigned MSQ_W     = 2 * MOD_W - 1;
  localparam int unsigned CNT_W     = $clog2(HALF_W);
  localparam int unsigned RED_STEPS = $clog2((2 * MAX_MODULUS) / MIN_MODULUS);

  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_PERMUTE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_LOAD_REJ = 2'd2
  } status_e;

  // Pair handed from one round cell to the next. The cell updates a and
  // passes the halves on swapped.
  typedef struct packed {
    logic              valid;
    logic [HALF_W-1:0] a;
    logic [HALF_W-1:0] b;
  } tok_t;

  // Clamp the programmed modulus into the supported range.
  function automatic logic [MOD_W-1:0] sat_modulus(input logic [MOD_W-1:0] v);
    logic [MOD_W-1:0] m;
    m = v;
    if (v < MOD_W'(MIN_MODULUS)) begin
      m = MOD_W'(MIN_MODULUS);
    end else if (v > MOD_W'(MAX_MODULUS)) begin
      m = MOD_W'(MAX_MODULUS);
    end
    return m;
  endfunction

  // Reduce a sum of two values below MAX_MODULUS by m. The quotient is below
  // 2*MAX_MODULUS/MIN_MODULUS, so a short restoring chain is enough.
  function automatic logic [HALF_W-1:0] mod_reduce(input logic [MOD_W-1:0] s,
                                                   input logic [MOD_W-1:0] m);
    logic [MOD_W+RED_STEPS-1:0] r;
    logic [MOD_W+RED_STEPS-1:0] sh;
    r = (MOD_W + RED_STEPS)'(s);
    for (int k = RED_STEPS - 1; k >= 0; k--) begin
      sh = (MOD_W + RED_STEPS)'(m) << k;
      if (r >= sh) begin
        r = r - sh;
      end
    end
    return r[HALF_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* design/keyed_feistel_index_permutation.sv */
// Top level of the keyed Feistel index permutation: control, configuration,
// the divider and the chain of round cells. Uses kfip_pkg, kfip_div, kfip_cell.
//
//   channel | handshake               | payload
//   --------+-------------------------+----------------------------------------
//   in      | in_valid_i / in_stall_o | mode, round_select, entry_slot,
//           |                         | entry_offset, index_in
//   out     | out_valid_o/out_stall_i | permuted_index, status
//   cfg     | cfg_we_i                | cfg_wdata_i (half_modulus)
//
// One transaction is in flight at a time. A permute passes through the ten
// divider steps and the divider's done flag, the table-read and modular-add
// registers of each round cell, then the result register and the output
// register. Loads and out-of-domain indexes skip the divider and the cells and
// go through the result register into the output register. The next transaction
// is accepted as soon as the result has moved into the output register, even
// while it is stalled; a result that cannot move keeps the input stalled.
// Reset clears control and modulus; round tables are undefined until loaded.
`default_nettype none

module keyed_feistel_index_permutation (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [kfip_pkg::MOD_W-1:0]  cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        mode_i,
  input  wire logic [kfip_pkg::ROUND_W-1:0] round_select_i,
  input  wire logic [kfip_pkg::HALF_W-1:0] entry_slot_i,
  input  wire logic [kfip_pkg::HALF_W-1:0] entry_offset_i,
  input  wire logic [kfip_pkg::IDX_W-1:0]  index_in_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [kfip_pkg::IDX_W-1:0]       permuted_index_o,
  output logic [1:0]                       status_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_RND  = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e                       state_q, state_d;
  logic [kfip_pkg::MOD_W-1:0]   mod_q;
  logic [kfip_pkg::MSQ_W-1:0]   msq_q;
  logic [kfip_pkg::MOD_W-1:0]   cfg_mod;
  logic [kfip_pkg::IDX_W-1:0]   res_idx_q, res_idx_d;
  kfip_pkg::status_e            res_status_q, res_status_d;
  logic                         out_valid_q;
  logic [kfip_pkg::IDX_W-1:0]   out_idx_q;
  kfip_pkg::status_e            out_status_q;

  logic                         accept;
  logic                         load_ok;
  logic                         in_range;
  logic                         div_start;
  logic                         div_done;
  logic [kfip_pkg::HALF_W-1:0]  div_quot;
  logic [kfip_pkg::HALF_W-1:0]  div_rem;
  logic                         take_result;
  kfip_pkg::tok_t               chain [kfip_pkg::ROUNDS+1];
  kfip_pkg::tok_t               last_tok;
  logic [kfip_pkg::HALF_W-1:0]  fin_left;
  logic [kfip_pkg::HALF_W-1:0]  fin_right;
  logic [kfip_pkg::MSQ_W-1:0]   perm_full;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);

  assign load_ok  = (round_select_i < kfip_pkg::ROUND_W'(kfip_pkg::ROUNDS))
                 && ({1'b0, entry_slot_i} < mod_q)
                 && ({1'b0, entry_offset_i} < mod_q);
  assign in_range = kfip_pkg::MSQ_W'(index_in_i) < msq_q;

  assign div_start = accept && (mode_i == kfip_pkg::MODE_PERMUTE) && in_range;

  // Configuration: keep the clamped modulus and its square.
  assign cfg_mod = kfip_pkg::sat_modulus(cfg_wdata_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= kfip_pkg::MOD_W'(kfip_pkg::HALF_MOD_RESET);
      msq_q <= kfip_pkg::MSQ_W'(kfip_pkg::HALF_MOD_RESET * kfip_pkg::HALF_MOD_RESET);
    end else if (cfg_we_i) begin
      mod_q <= cfg_mod;
      msq_q <= kfip_pkg::MSQ_W'(cfg_mod * cfg_mod);
    end
  end

  kfip_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (index_in_i),
    .divisor_i  (mod_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign chain[0].valid = div_done;
  assign chain[0].a     = div_quot;
  assign chain[0].b     = div_rem;

  for (genvar r = 0; r < kfip_pkg::ROUNDS; r++) begin : g_round
    logic wr_en;
    assign wr_en = accept && (mode_i == kfip_pkg::MODE_LOAD) && load_ok
                && (round_select_i == kfip_pkg::ROUND_W'(r));
    kfip_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .modulus_i (mod_q),
      .wr_en_i   (wr_en),
      .wr_addr_i (entry_slot_i),
      .wr_data_i (entry_offset_i),
      .tok_i     (chain[r]),
      .tok_o     (chain[r+1])
    );
  end

  // Each cell swaps the halves, so after an odd number of rounds the left
  // half sits in b.
  assign last_tok  = chain[kfip_pkg::ROUNDS];
  assign fin_left  = (kfip_pkg::ROUNDS % 2 == 1) ? last_tok.b : last_tok.a;
  assign fin_right = (kfip_pkg::ROUNDS % 2 == 1) ? last_tok.a : last_tok.b;
  assign perm_full = kfip_pkg::MSQ_W'(fin_left * mod_q)
                   + kfip_pkg::MSQ_W'(fin_right);

  assign take_result = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d      = state_q;
    res_idx_d    = res_idx_q;
    res_status_d = res_status_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_idx_d = '0;
          if (mode_i == kfip_pkg::MODE_LOAD) begin
            res_status_d = load_ok ? kfip_pkg::ST_OK : kfip_pkg::ST_LOAD_REJ;
            state_d      = S_DONE;
          end else if (!in_range) begin
            res_status_d = kfip_pkg::ST_RANGE;
            state_d      = S_DONE;
          end else begin
            res_status_d = kfip_pkg::ST_OK;
            state_d      = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_RND;
        end
      end
      S_RND: begin
        if (last_tok.valid) begin
          res_idx_d = perm_full[kfip_pkg::IDX_W-1:0];
          state_d   = S_DONE;
        end
      end
      S_DONE: begin
        if (take_result) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (take_result) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_idx_q    <= res_idx_d;
    res_status_q <= res_status_d;
    if (take_result) begin
      out_idx_q    <= res_idx_q;
      out_status_q <= res_status_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign permuted_index_o = out_idx_q;
  assign status_o         = out_status_q;

  // An accepted transaction always moves the controller out of idle.
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != S_IDLE))
    else $error("accepted transaction did not leave idle");

  // The divider only finishes while the controller waits for it.
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside the divide state");

  // A token leaves the last round cell only while rounds are running.
  a_chain_out_in_rnd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_tok.valid |-> (state_q == S_RND))
    else $error("round chain produced a token outside the round state");

  // Error and load results carry a zero index.
  a_error_zero_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != kfip_pkg::ST_OK)) |-> (permuted_index_o == '0))
    else $error("error result with nonzero index");

endmodule

`default_nettype wire

/* design/kfip_div.sv */
// Restoring divider that splits an index into quotient and remainder by the
// half modulus, one quotient bit per cycle. Uses kfip_pkg.
`default_nettype none

module kfip_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [kfip_pkg::IDX_W-1:0]  dividend_i,
  input  wire logic [kfip_pkg::MOD_W-1:0]  divisor_i,
  output logic                             done_o,
  output logic [kfip_pkg::HALF_W-1:0]      quot_o,
  output logic [kfip_pkg::HALF_W-1:0]      rem_o
);

  logic                        busy_q;
  logic                        done_q;
  logic [kfip_pkg::CNT_W-1:0]  cnt_q;
  logic [kfip_pkg::IDX_W-1:0]  rem_q;
  logic [kfip_pkg::HALF_W-1:0] quot_q;
  logic [kfip_pkg::IDX_W:0]    shifted;
  logic                        fits;

  // The index is below m*m, so the quotient fits in HALF_W bits.
  assign shifted = (kfip_pkg::IDX_W + 1)'(divisor_i) << cnt_q;
  assign fits    = {1'b0, rem_q} >= shifted;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= kfip_pkg::CNT_W'(kfip_pkg::HALF_W - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= dividend_i;
      quot_q <= '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= rem_q - shifted[kfip_pkg::IDX_W-1:0];
      end
      quot_q[cnt_q] <= fits;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q[kfip_pkg::HALF_W-1:0];

endmodule

`default_nettype wire

/* design/kfip_cell.sv */
// One Feistel round cell: holds its round table in a local memory, adds the
// looked-up offset to one half modulo m and hands the swapped pair onward.
// Uses kfip_pkg.
`default_nettype none

module kfip_cell (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [kfip_pkg::MOD_W-1:0]  modulus_i,
  input  wire logic                        wr_en_i,
  input  wire logic [kfip_pkg::HALF_W-1:0] wr_addr_i,
  input  wire logic [kfip_pkg::HALF_W-1:0] wr_data_i,
  input  wire kfip_pkg::tok_t              tok_i,
  output kfip_pkg::tok_t                   tok_o
);

  logic [kfip_pkg::HALF_W-1:0] table_mem [kfip_pkg::MAX_MODULUS];
  logic [kfip_pkg::HALF_W-1:0] rd_q;
  logic                        mid_valid_q;
  logic [kfip_pkg::HALF_W-1:0] mid_a_q;
  logic [kfip_pkg::HALF_W-1:0] mid_b_q;
  logic                        out_valid_q;
  logic [kfip_pkg::HALF_W-1:0] out_a_q;
  logic [kfip_pkg::HALF_W-1:0] out_b_q;
  logic [kfip_pkg::MOD_W-1:0]  sum;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      table_mem[wr_addr_i] <= wr_data_i;
    end
    rd_q <= table_mem[tok_i.b];
  end

  assign sum = {1'b0, mid_a_q} + {1'b0, rd_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mid_valid_q <= tok_i.valid;
      out_valid_q <= mid_valid_q;
    end
  end

  // The updated half moves to b so that the next cell updates the other one.
  always_ff @(posedge clk_i) begin
    mid_a_q <= tok_i.a;
    mid_b_q <= tok_i.b;
    out_a_q <= mid_b_q;
    out_b_q <= kfip_pkg::mod_reduce(sum, modulus_i);
  end

  assign tok_o.valid = out_valid_q;
  assign tok_o.a     = out_a_q;
  assign tok_o.b     = out_b_q;

endmodule

`default_nettype wire
